/* hdl/qefa_pkg.sv */
// Shared types, opcodes and constants for the GF(p^2) arithmetic unit.
package qefa_pkg;

  localparam int WordBits = 64;
  localparam int CntBits = $clog2(WordBits + 1);

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_MUL = 3'd3,
    OP_INV = 3'd4
  } opcode_t;

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpNeg = 3'd2;
  localparam logic [2:0] OpMul = 3'd3;
  localparam logic [2:0] OpInv = 3'd4;

  // One queued transaction between front and back.
  typedef struct packed {
    logic [2:0] op;
    word_t      ar;
    word_t      ai;
    word_t      br;
    word_t      bi;
  } item_t;

  // Modular add of two values below m.
  function automatic word_t mod_add(word_t a, word_t b, word_t m);
    logic [WordBits:0] s;
    logic [WordBits:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, m};
    mod_add = d[WordBits] ? s[WordBits-1:0] : d[WordBits-1:0];
  endfunction

  // Modular subtract of two values below m.
  function automatic word_t mod_sub(word_t a, word_t b, word_t m);
    mod_sub = (a >= b) ? (a - b) : (a + (m - b));
  endfunction

endpackage

/* hdl/qefa_front.sv */
// Front end: reduce operand parts modulo p one bit per cycle and queue them.
module qefa_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        opcode,
  input  qefa_pkg::word_t   a_real,
  input  qefa_pkg::word_t   a_imag,
  input  qefa_pkg::word_t   b_real,
  input  qefa_pkg::word_t   b_imag,
  input  qefa_pkg::word_t   m,
  output logic              q_valid,
  output qefa_pkg::item_t   q_item,
  input  logic              q_take
);

  localparam int N = qefa_pkg::WordBits;

  logic                         run;
  logic [qefa_pkg::CntBits-1:0] cnt;
  logic [2:0]                   op;
  qefa_pkg::word_t              src [4];
  qefa_pkg::word_t              rem [4];
  qefa_pkg::word_t              rem_next [4];

  // Two-entry queue
  qefa_pkg::item_t q_mem [2];
  logic            wp, rp;
  logic [1:0]      fill;
  logic            push;

  assign busy = run || (fill == 2'd2);

  // One restoring step per part: shift in next bit, subtract m if fits
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [N:0] t;
      logic [N:0] d;
      t = {rem[k], src[k][N-1]};
      d = t - {1'b0, m};
      rem_next[k] = d[N] ? t[N-1:0] : d[N-1:0];
    end
  end

  assign push = run && (cnt == qefa_pkg::CntBits'(N - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start && !busy) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 1'b1;
      if (push) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op     <= opcode;
      src[0] <= a_real;
      src[1] <= a_imag;
      src[2] <= b_real;
      src[3] <= b_imag;
      for (int k = 0; k < 4; k++) rem[k] <= '0;
    end else if (run) begin
      for (int k = 0; k < 4; k++) begin
        rem[k] <= rem_next[k];
        src[k] <= {src[k][N-2:0], 1'b0};
      end
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (q_take) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, q_take};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp] <= '{op: op, ar: rem_next[0], ai: rem_next[1],
                     br: rem_next[2], bi: rem_next[3]};
    end
  end

  assign q_valid = (fill != 2'd0);
  assign q_item  = q_mem[rp];

endmodule

/* hdl/qefa_back.sv */
// Back end: sequencer over a shared bit-serial modular multiplier.
module qefa_back (
  input  logic            clk,
  input  logic            rst,
  input  qefa_pkg::word_t m,
  input  logic            q_valid,
  input  qefa_pkg::item_t q_item,
  output logic            q_take,
  output logic            done,
  output qefa_pkg::word_t res_real,
  output qefa_pkg::word_t res_imag,
  output logic            no_inverse
);

  localparam int N = qefa_pkg::WordBits;
  localparam int CB = qefa_pkg::CntBits;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MUL1  = 12'b000000000010,
    S_MUL2  = 12'b000000000100,
    S_MUL3  = 12'b000000001000,
    S_MUL4  = 12'b000000010000,
    S_NORM  = 12'b000000100000,
    S_DIV   = 12'b000001000000,
    S_QMUL  = 12'b000010000000,
    S_FIN1  = 12'b000100000000,
    S_FIN2  = 12'b001000000000,
    S_WAIT  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t          state;
  qefa_pkg::item_t it;

  // Shared shift-and-add multiplier
  qefa_pkg::word_t ma, mb, acc;
  logic [CB-1:0]   mcnt;
  logic            mrun;
  qefa_pkg::word_t acc_next;
  logic            mdone;

  qefa_pkg::word_t p0, p1, p2;
  // Euclid state
  qefa_pkg::word_t r0, r1, t0, t1, q, dr;
  logic [CB-1:0]   dcnt;

  always_comb begin
    qefa_pkg::word_t d2;
    d2 = qefa_pkg::mod_add(acc, acc, m);
    acc_next = mb[N-1] ? qefa_pkg::mod_add(d2, ma, m) : d2;
  end
  assign mdone = mrun && (mcnt == CB'(N - 1));

  assign q_take = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mrun  <= 1'b0;
      mcnt  <= '0;
      done  <= 1'b0;
      dcnt  <= '0;
    end else begin
      done <= 1'b0;
      // Advance the multiplier; a state below may reload it
      if (mrun) begin
        mcnt <= mcnt + 1'b1;
        acc  <= acc_next;
        mb   <= {mb[N-2:0], 1'b0};
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            it <= q_item;
            case (q_item.op)
              qefa_pkg::OpAdd: begin
                res_real <= qefa_pkg::mod_add(q_item.ar, q_item.br, m);
                res_imag <= qefa_pkg::mod_add(q_item.ai, q_item.bi, m);
                no_inverse <= 1'b0;
                state <= S_OUT;
              end
              qefa_pkg::OpSub: begin
                res_real <= qefa_pkg::mod_sub(q_item.ar, q_item.br, m);
                res_imag <= qefa_pkg::mod_sub(q_item.ai, q_item.bi, m);
                no_inverse <= 1'b0;
                state <= S_OUT;
              end
              qefa_pkg::OpNeg: begin
                res_real <= qefa_pkg::mod_sub('0, q_item.ar, m);
                res_imag <= qefa_pkg::mod_sub('0, q_item.ai, m);
                no_inverse <= 1'b0;
                state <= S_OUT;
              end
              qefa_pkg::OpMul: begin
                ma <= q_item.ar; mb <= q_item.br; acc <= '0;
                mrun <= 1'b1; mcnt <= '0;
                state <= S_MUL1;
              end
              qefa_pkg::OpInv: begin
                ma <= q_item.ar; mb <= q_item.ar; acc <= '0;
                mrun <= 1'b1; mcnt <= '0;
                state <= S_MUL1;
              end
              default: begin
                res_real <= '0;
                res_imag <= '0;
                no_inverse <= 1'b0;
                state <= S_OUT;
              end
            endcase
          end
        end
        // mul: ar*br, ai*bi, ar*bi, ai*br; inv: ar*ar, ai*ai
        S_MUL1: if (mdone) begin
          p0 <= acc_next; acc <= '0; mcnt <= '0;
          ma <= it.ai; mb <= (it.op == qefa_pkg::OpInv) ? it.ai : it.bi;
          state <= S_MUL2;
        end
        S_MUL2: if (mdone) begin
          if (it.op == qefa_pkg::OpInv) begin
            mrun <= 1'b0;
            p1 <= qefa_pkg::mod_add(p0, acc_next, m);
            state <= S_NORM;
          end else begin
            p0 <= qefa_pkg::mod_sub(p0, acc_next, m);
            acc <= '0; mcnt <= '0;
            ma <= it.ar; mb <= it.bi;
            state <= S_MUL3;
          end
        end
        S_MUL3: if (mdone) begin
          p1 <= acc_next; acc <= '0; mcnt <= '0;
          ma <= it.ai; mb <= it.br;
          state <= S_MUL4;
        end
        S_MUL4: if (mdone) begin
          mrun <= 1'b0;
          res_real <= p0;
          res_imag <= qefa_pkg::mod_add(p1, acc_next, m);
          no_inverse <= 1'b0;
          state <= S_OUT;
        end
        // Start extended Euclid on the norm
        S_NORM: begin
          r0 <= m; r1 <= p1; t0 <= '0; t1 <= {{(N-1){1'b0}}, 1'b1};
          if (p1 == '0) begin
            res_real <= '0; res_imag <= '0; no_inverse <= 1'b1;
            state <= S_OUT;
          end else begin
            q <= '0; dr <= '0; dcnt <= '0; p2 <= m;
            state <= S_DIV;
          end
        end
        // Restoring division r0 / r1, one quotient bit a cycle
        S_DIV: begin
          logic [N:0] t;
          logic [N:0] d;
          t = {dr, p2[N-1]};
          d = t - {1'b0, r1};
          p2 <= {p2[N-2:0], 1'b0};
          dr <= d[N] ? t[N-1:0] : d[N-1:0];
          q  <= {q[N-2:0], ~d[N]};
          dcnt <= dcnt + 1'b1;
          if (dcnt == CB'(N - 1)) begin
            state <= S_QMUL;
          end
        end
        // t_new = t0 - (q mod m)*t1; q <= r0 < ... q may exceed m? reduce once
        S_QMUL: begin
          if (!mrun) begin
            ma <= t1; mb <= (q >= m) ? q - m : q; acc <= '0;
            mrun <= 1'b1; mcnt <= '0;
          end else if (mdone) begin
            mrun <= 1'b0;
            t0 <= t1;
            t1 <= qefa_pkg::mod_sub(t0, acc_next, m);
            r0 <= r1;
            r1 <= dr;
            if (dr == '0) begin
              state <= S_FIN1;
            end else begin
              q <= '0; dr <= '0; dcnt <= '0; p2 <= r1;
              state <= S_DIV;
            end
          end
        end
        // r0 now gcd, t0 inverse
        S_FIN1: begin
          if (r0 != {{(N-1){1'b0}}, 1'b1}) begin
            res_real <= '0; res_imag <= '0; no_inverse <= 1'b1;
            state <= S_OUT;
          end else begin
            ma <= it.ar; mb <= t0; acc <= '0; mrun <= 1'b1; mcnt <= '0;
            p2 <= t0;
            state <= S_FIN2;
          end
        end
        S_FIN2: if (mdone) begin
          res_real <= acc_next;
          ma <= qefa_pkg::mod_sub('0, it.ai, m); mb <= p2;
          acc <= '0; mcnt <= '0;
          state <= S_WAIT;
        end
        S_WAIT: if (mdone) begin
          mrun <= 1'b0;
          res_imag <= acc_next;
          no_inverse <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/quadratic_extension_field_alu_core.sv */
// Top level of the GF(p^2) arithmetic unit with APB modulus register.
// Parts are reduced mod p bit-serially. Add, subtract and negate skip the multiplier;
// multiply runs four products on one shared multiplier; invert runs two norm products,
// extended Euclid rounds and two final products. Intake waits while reducing or while
// the two-entry queue is full, so it can run ahead of the back end; results strobe for
// one cycle. Synchronous reset empties the queue, idles both parts, sets modulus to 3.
module quadratic_extension_field_alu_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            opcode,
  input  qefa_pkg::word_t       a_real,
  input  qefa_pkg::word_t       a_imag,
  input  qefa_pkg::word_t       b_real,
  input  qefa_pkg::word_t       b_imag,
  output logic                  done,
  output qefa_pkg::word_t       res_real,
  output qefa_pkg::word_t       res_imag,
  output logic                  no_inverse,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  qefa_pkg::word_t modulus;
  qefa_pkg::word_t m;
  logic            q_valid, q_take;
  qefa_pkg::item_t q_item;

  assign pready = 1'b1;
  assign m = (modulus < qefa_pkg::WordBits'(3)) ? qefa_pkg::WordBits'(3) : modulus;
  assign prdata = (paddr == 3'd0) ? 64'(modulus) : 64'd0;

  // Hold the modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= qefa_pkg::WordBits'(3);
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      modulus <= pwdata[qefa_pkg::WordBits-1:0];
    end
  end

  qefa_front u_front (
    .clk, .rst, .start, .busy, .opcode, .a_real, .a_imag, .b_real, .b_imag,
    .m, .q_valid, .q_item, .q_take
  );

  qefa_back u_back (
    .clk, .rst, .m, .q_valid, .q_item, .q_take, .done,
    .res_real, .res_imag, .no_inverse
  );

endmodule
